// ===== hw/rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 24;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [15:0] REG_WIDTH  = 16'd0;
  localparam logic [15:0] REG_HEIGHT = 16'd1;

  typedef struct packed {
    logic       command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic             ld_px;     // capture the accepted pixel
    logic             wr;        // write line buffers at addr
    logic [COL_W-1:0] addr;
    logic             shift;     // shift window with px / line data
    logic             drain;     // load window column from lines, zero bottom
    logic             shift_z;   // shift in an all-zero column
    logic             ld_sum;    // latch window sums and count
    logic [2:0]       colv;
    logic [2:0]       rowv;
    logic             fend;
    logic             div_go;
  } bb3_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } bb3_stat_t;

endpackage

// ===== hw/rtl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/bb3_datapath.sv =====
// ----------------------------------------------------------------------------
// bb3_datapath
// Line buffers, 3x3 window, masked sums and a restoring divider.
// ----------------------------------------------------------------------------
module bb3_datapath import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bb3_cmd_t          cmd,
  input  logic [PIX_W-1:0]  px,
  output bb3_stat_t         stat,
  output out_beat_t         result
);
  logic [PIX_W-1:0] up_q, mid_q;
  logic [PIX_W-1:0] px_q;
  logic [PIX_W-1:0] win [9];
  logic [11:0]      sum [3];
  logic [3:0]       cnt;
  logic             fend;
  // divider: three channels in parallel, one quotient bit a cycle
  logic [12:0]      num [3];
  logic [12:0]      rem [3];
  logic [7:0]       quo [3];
  logic [4:0]       den;
  logic [3:0]       step;
  logic             busy, done;

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(cmd.wr), .addr(cmd.addr), .wdata(mid_q), .rdata(up_q));
  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(cmd.wr), .addr(cmd.addr), .wdata(px_q), .rdata(mid_q));

  always_ff @(posedge clk) begin
    if (cmd.ld_px) px_q <= px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cmd.shift || cmd.drain || cmd.shift_z) begin
      for (int i = 0; i < 6; i++) win[i] <= win[i+3];
      win[6] <= cmd.shift_z ? '0 : up_q;
      win[7] <= cmd.shift_z ? '0 : mid_q;
      win[8] <= cmd.shift ? px_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_sum) begin
      logic [11:0] s [3];
      logic [3:0]  n;
      n = '0;
      for (int j = 0; j < 3; j++) s[j] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          if (cmd.colv[k] && cmd.rowv[r]) begin
            s[0] = s[0] + 12'(win[3*k+r][23:16]);
            s[1] = s[1] + 12'(win[3*k+r][15:8]);
            s[2] = s[2] + 12'(win[3*k+r][7:0]);
            n = n + 4'd1;
          end
        end
      end
      for (int j = 0; j < 3; j++) sum[j] <= s[j];
      cnt  <= (n == 4'd0) ? 4'd1 : n;
      fend <= cmd.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.div_go) begin
        busy <= 1'b1;
        step <= 4'd12;
        den  <= {cnt, 1'b0};
        for (int j = 0; j < 3; j++) begin
          num[j] <= {sum[j], 1'b0} + 13'(cnt);
          rem[j] <= '0;
        end
      end else if (busy) begin
        for (int j = 0; j < 3; j++) begin
          logic [13:0] t;
          t = {rem[j], num[j][12]};
          num[j] <= {num[j][11:0], 1'b0};
          if (t >= 14'(den)) begin
            rem[j] <= 13'(t - 14'(den));
            quo[j] <= {quo[j][6:0], 1'b1};
          end else begin
            rem[j] <= t[12:0];
            quo[j] <= {quo[j][6:0], 1'b0};
          end
        end
        if (step == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - 4'd1;
      end
    end
  end

  assign stat.div_busy = busy;
  assign stat.div_done = done;
  assign result.out_red   = quo[0];
  assign result.out_green = quo[1];
  assign result.out_blue  = quo[2];
  assign result.frame_end = fend;
endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3_ctrl
// Frame position tracking and sequencing of reads, window shifts and emits.
// ----------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_command,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  bb3_stat_t   stat,
  output bb3_cmd_t    cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_WIN   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;

  logic [3:0]       state, state_next;
  logic [10:0]      fw;
  logic [15:0]      fh;
  logic [15:0]      row_index;
  logic [COL_W-1:0] column_index;
  logic [10:0]      drain_index;
  logic             is_flush;
  logic             second;   // row-end extra result pending
  logic             is_edge;  // current emit is the row-end one
  logic [10:0]      w_eff;
  logic [15:0]      h_eff;
  logic [COL_W-1:0] c_eff, addr;
  logic             take;
  logic [15:0]      px_row;

  assign w_eff = (fw == 11'd0) ? 11'd1 :
                 (fw > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : fw;
  assign h_eff = (fh == 16'd0) ? 16'd1 : fh;
  assign c_eff = (11'(column_index) >= w_eff) ? COL_W'(w_eff - 11'd1) : column_index;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign take = in_valid && (state == S_IDLE);
  // row of the pixel being processed, after the position has advanced
  assign px_row = (column_index == '0) ? row_index - 16'd1 : row_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fw <= 11'd1024;
      fh <= 16'd1;
      row_index <= '0;
      column_index <= '0;
      drain_index <= '0;
      is_flush <= 1'b0;
      second <= 1'b0;
      is_edge <= 1'b0;
      addr <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && (cfg_index == 16'(REG_WIDTH) || cfg_index == 16'(REG_HEIGHT))) begin
        if (cfg_index == 16'(REG_WIDTH)) fw <= cfg_data[10:0];
        else fh <= cfg_data;
        row_index <= '0;
        column_index <= '0;
        drain_index <= '0;
      end
      if (state == S_IDLE && state_next == S_RD) begin
        is_flush <= in_command;
        // a drain beat reads the column right of its own
        if (in_command == CMD_FLUSH) begin
          addr <= (drain_index == 11'd0) ? '0 : COL_W'(drain_index + 11'd1);
        end else begin
          addr <= c_eff;
        end
      end
      if (state == S_WIN && is_flush && drain_index == 11'd0 && addr == '0) begin
        addr <= COL_W'(1);
      end
      if (state == S_RD && !is_flush) begin
        second <= (row_index != 16'd0) && (11'(addr) == w_eff - 11'd1);
        if (11'(addr) + 11'd1 >= w_eff) begin
          column_index <= '0;
          row_index <= row_index + 16'd1;
        end else begin
          column_index <= addr + COL_W'(1);
        end
      end
      if (state == S_WIN) is_edge <= 1'b0;
      if (state == S_EDGE) begin
        is_edge <= 1'b1;
        second <= 1'b0;
      end
      if (state == S_SUM && is_flush) begin
        drain_index <= drain_index + 11'd1;
      end
      if (state == S_OUT && !out_stall && is_flush &&
          drain_index >= w_eff) begin
        row_index <= '0;
        column_index <= '0;
        drain_index <= '0;
      end
    end
  end

  always_comb begin
    logic [10:0] d;
    logic [10:0] a;
    d = drain_index;
    a = 11'(addr);
    state_next = state;
    cmd = '0;
    cmd.addr = addr;
    unique case (state)
      S_IDLE: begin
        cmd.ld_px = take;
        if (take) begin
          if (in_command == CMD_FLUSH) begin
            if (row_index >= h_eff && drain_index < w_eff) state_next = S_RD;
          end else if (row_index < h_eff) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_WIN;
      end
      S_WIN: begin
        // read data valid now
        if (is_flush) begin
          cmd.drain = 1'b1;
          // first drain beat loads column zero before column one
          state_next = (drain_index == 11'd0 && addr == '0) ? S_RD : S_SUM;
        end else begin
          cmd.shift = 1'b1;
          cmd.wr = 1'b1;
          // a row-0 pixel never emits
          if (px_row == 16'd0) state_next = S_IDLE;
          else if (addr != '0) state_next = S_SUM;
          else if (second) state_next = S_EDGE;
          else state_next = S_IDLE;
        end
      end
      S_EDGE: begin
        cmd.shift_z = 1'b1;
        state_next = second ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.ld_sum = 1'b1;
        if (is_flush) begin
          cmd.colv[0] = (d >= 11'd1);
          cmd.colv[1] = 1'b1;
          cmd.colv[2] = (d + 11'd1 < w_eff);
          cmd.rowv = {1'b0, 1'b1, (h_eff >= 16'd2)};
          cmd.fend = (d + 11'd1 >= w_eff);
        end else if (is_edge) begin
          cmd.colv = {1'b0, 1'b1, (a >= 11'd1)};
          cmd.rowv = {1'b1, 1'b1, (px_row >= 16'd2)};
        end else begin
          cmd.colv = {1'b1, 1'b1, (a >= 11'd2)};
          cmd.rowv = {1'b1, 1'b1, (px_row >= 16'd2)};
        end
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_go = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = (!is_flush && !is_edge && second) ? S_EDGE : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/box_blur_3x3_edge_aware_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// Streaming 3x3 box blur of an RGB frame with edge-aware averaging.
// ----------------------------------------------------------------------------
// One beat at a time: a pixel beat that gives no result holds the input for
// a line buffer read and a window update, and a beat outside the frame is
// consumed without a stall. Each result adds a sum, the wait on the 13-step
// restoring divider that runs the three channels in parallel, and the output
// hold while out_stall is high; the first flush of a drain adds a line read.
// Output (r-1,c-1) appears after pixel (r,c); the last pixel of a row gives a
// second result, and flush beats drain the final row.
// Writing either register restarts the frame.
module box_blur_3x3_edge_aware_top import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);
  bb3_cmd_t  cmd;
  bb3_stat_t stat;

  bb3_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_command(in_data.command),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd));

  bb3_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .px({in_data.in_red, in_data.in_green, in_data.in_blue}),
    .stat(stat), .result(out_data));

  a_div_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !stat.div_busy) else $error("divider restarted while busy");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !stat.div_busy) else $error("result shown during divide");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
endmodule

// ===== tb/sv/tb_box_blur_3x3_edge_aware_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware_top
// Self-checking bench for the streaming 3x3 edge-aware box blur. The bench
// sends whole frames of several sizes and register settings, then random
// frames mixed with stray pixels and early flushes. A cycle-free model of the
// blur predicts every output beat, and a monitor compares each output beat
// with those predictions in order.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware_top;
  import bb3_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  box_blur_3x3_edge_aware_top dut (.*);

  always #5 clk = ~clk;

  // blur model state
  logic [23:0] upper_row [MAX_WIDTH];
  logic [23:0] middle_row [MAX_WIDTH];
  logic [23:0] win [9];
  int unsigned row_cnt, col_cnt, drain_cnt;
  int unsigned width_reg = 1024, height_reg = 1;

  in_beat_t  pending_beats [$];
  out_beat_t expected_pixels [$];
  int        mismatches = 0;
  int        idle_pct = 0, stall_pct = 0;
  bit        taken = 1'b0;

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic out_beat_t box_mean(logic [23:0] cols [3][3], bit colv [3],
                                         bit rowv [3], bit fend);
    int unsigned s [3];
    int unsigned cnt;
    out_beat_t o;
    s = '{0, 0, 0};
    cnt = 0;
    for (int k = 0; k < 3; k++)
      for (int r = 0; r < 3; r++)
        if (colv[k] && rowv[r]) begin
          s[0] += cols[k][r][23:16];
          s[1] += cols[k][r][15:8];
          s[2] += cols[k][r][7:0];
          cnt++;
        end
    if (cnt == 0) cnt = 1;
    o.out_red   = 8'((2 * s[0] + cnt) / (2 * cnt));
    o.out_green = 8'((2 * s[1] + cnt) / (2 * cnt));
    o.out_blue  = 8'((2 * s[2] + cnt) / (2 * cnt));
    o.frame_end = fend;
    return o;
  endfunction

  function automatic void restart_frame();
    row_cnt = 0;
    col_cnt = 0;
    drain_cnt = 0;
  endfunction

  function automatic void predict_blur(in_beat_t b);
    int unsigned w, h, c, r;
    int cc;
    logic [23:0] cols [3][3];
    bit colv [3];
    bit rowv [3];
    bit last;
    w = eff_w();
    h = eff_h();
    if (b.command == CMD_FLUSH) begin
      if (row_cnt < h || drain_cnt >= w) return;
      rowv = '{h >= 2, 1'b1, 1'b0};
      for (int k = 0; k < 3; k++) begin
        cc = int'(drain_cnt) + k - 1;
        colv[k] = (cc >= 0) && (cc < int'(w));
        cols[k][0] = colv[k] ? upper_row[cc] : '0;
        cols[k][1] = colv[k] ? middle_row[cc] : '0;
        cols[k][2] = '0;
      end
      drain_cnt++;
      last = (drain_cnt >= w);
      expected_pixels.push_back(box_mean(cols, colv, rowv, last));
      if (last) restart_frame();
      return;
    end
    if (row_cnt >= h) return;
    r = row_cnt;
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    for (int i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = upper_row[c];
    win[7] = middle_row[c];
    win[8] = {b.in_red, b.in_green, b.in_blue};
    upper_row[c] = middle_row[c];
    middle_row[c] = win[8];
    if (r >= 1) begin
      rowv = '{r >= 2, 1'b1, 1'b1};
      if (c >= 1) begin
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++) cols[k][j] = win[3 * k + j];
        colv = '{c >= 2, 1'b1, 1'b1};
        expected_pixels.push_back(box_mean(cols, colv, rowv, 1'b0));
      end
      if (c == w - 1) begin
        for (int k = 0; k < 2; k++)
          for (int j = 0; j < 3; j++) cols[k][j] = win[3 * (k + 1) + j];
        for (int j = 0; j < 3; j++) cols[2][j] = '0;
        colv = '{c >= 1, 1'b1, 1'b0};
        expected_pixels.push_back(box_mean(cols, colv, rowv, 1'b0));
      end
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // input side: accept at rising edge, drive at falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_blur(in_data);
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || taken)) begin
      taken = 1'b0;
      if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // output side
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %p", out_data);
      end else begin
        e = expected_pixels.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic [15:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == 16'(REG_WIDTH)) begin
      width_reg = val & 16'h7FF;
      restart_frame();
    end else if (idx == 16'(REG_HEIGHT)) begin
      height_reg = val;
      restart_frame();
    end
  endtask

  // sender holds off until every result is back, then covers the latency
  task automatic drain_idle();
    while (pending_beats.size() > 0 || in_valid) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic void push_pixel(logic [23:0] px);
    in_beat_t b;
    b.command = CMD_PIXEL;
    {b.in_red, b.in_green, b.in_blue} = px;
    pending_beats.push_back(b);
  endfunction

  function automatic void push_flush();
    in_beat_t b;
    b = in_beat_t'(25'($urandom));
    b.command = CMD_FLUSH;
    pending_beats.push_back(b);
  endfunction

  // fill: 0 random, 1 all zero, 2 all ones
  function automatic int queue_frame(int fill);
    int n;
    n = 0;
    for (int i = 0; i < eff_w() * eff_h(); i++) begin
      push_pixel(fill == 1 ? 24'h0 : fill == 2 ? 24'hFFFFFF : 24'($urandom));
      n++;
    end
    for (int i = 0; i < eff_w(); i++) begin
      push_flush();
      n++;
    end
    return n;
  endfunction

  task automatic set_phase(int p);
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  initial begin
    int sent, frame_no, n;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero width and height act as one: early flush, single-pixel frame, then a stray flush
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd0);
    push_flush();
    n = queue_frame(0);
    push_flush();
    drain_idle();
    // 3x3 extremes, unknown register index, stray pixels beyond the frame
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd3);
    n = queue_frame(2);
    drain_idle();
    n = queue_frame(1);
    drain_idle();
    write_reg(16'd2, 16'hFFFF);
    for (int i = 0; i < 9; i++) push_pixel(24'($urandom));
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    for (int i = 0; i < 3; i++) push_flush();
    drain_idle();
    // single column and single row frames
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd4);
    n = queue_frame(0);
    drain_idle();
    write_reg(REG_WIDTH, 16'd5);
    write_reg(REG_HEIGHT, 16'd1);
    n = queue_frame(0);
    drain_idle();
    // tallest frame: a few rows, then abandoned by a restart
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_WIDTH, 16'd2);
    for (int i = 0; i < 8; i++) push_pixel(24'($urandom));
    drain_idle();
    // oversize width acts as the full line: part of a first row, then restart
    write_reg(REG_HEIGHT, 16'd2);
    write_reg(REG_WIDTH, 16'd2047);
    for (int i = 0; i < 40; i++) push_pixel(24'($urandom));
    drain_idle();

    sent = 0;
    frame_no = 0;
    while (sent < 600) begin
      set_phase(frame_no);
      if (frame_no == 0 || $urandom_range(3) == 0) begin
        drain_idle();
        write_reg(REG_WIDTH, $urandom_range(9) == 0 ? 16'($urandom_range(40, 1))
                                                     : 16'($urandom_range(8, 1)));
        write_reg(REG_HEIGHT, $urandom_range(15) == 0 ? 16'd0 : 16'($urandom_range(6, 1)));
      end
      if ($urandom_range(7) == 0) begin
        push_flush();
        sent++;
      end
      for (int i = 0; i < eff_w() * eff_h(); i++) push_pixel(24'($urandom));
      sent += eff_w() * eff_h();
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) push_pixel(24'($urandom));
      end
      for (int i = 0; i < eff_w(); i++) push_flush();
      sent += eff_w();
      // long stretches of back-to-back frames without a pause
      if ($urandom_range(2) == 0) drain_idle();
      frame_no++;
    end
    drain_idle();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ram.sv
hw/rtl/bb3_datapath.sv
hw/rtl/bb3_ctrl.sv
hw/rtl/box_blur_3x3_edge_aware_top.sv
tb/sv/tb_box_blur_3x3_edge_aware_top.sv
